### sv/mtm_pkg.sv
// Package: shared types, codes and lookup functions for the MUS to MIDI transcoder.
`timescale 1ns / 1ps

package mtm_pkg;

    // Result status codes.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_EVENT  = 3'd1;
    localparam logic [2:0] ST_BAD_SYSTEM = 3'd2;
    localparam logic [2:0] ST_BAD_CTRL   = 3'd3;
    localparam logic [2:0] ST_END        = 3'd4;

    // MUS event kinds, bits 6..4 of the event byte.
    localparam logic [2:0] KIND_RELEASE = 3'd0;
    localparam logic [2:0] KIND_PLAY    = 3'd1;
    localparam logic [2:0] KIND_PITCH   = 3'd2;
    localparam logic [2:0] KIND_SYSTEM  = 3'd3;
    localparam logic [2:0] KIND_CTRL    = 3'd4;
    localparam logic [2:0] KIND_END     = 3'd6;

    // MIDI status nibbles.
    localparam logic [3:0] MIDI_NOTE_OFF = 4'h8;
    localparam logic [3:0] MIDI_NOTE_ON  = 4'h9;
    localparam logic [3:0] MIDI_CTRL     = 4'hB;
    localparam logic [3:0] MIDI_PROGRAM  = 4'hC;
    localparam logic [3:0] MIDI_PITCH    = 4'hE;

    localparam logic [7:0] MIDI_META     = 8'hFF;
    localparam logic [7:0] MIDI_END_TRK  = 8'h2F;
    localparam logic [7:0] RELEASE_VEL   = 8'h40;
    localparam logic [6:0] VEL_RESET     = 7'h7F;

    typedef enum logic [2:0] {
        PH_EVENT,
        PH_OPERAND,
        PH_VELOCITY,
        PH_CTRL_VALUE,
        PH_DELAY,
        PH_HALT
    } phase_t;

    // One group of output bytes caused by a single input item.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic [2:0]      status;
    } cmd_t;

    // MIDI channel status byte, with channels 9 and 15 swapped.
    function automatic logic [7:0] chan_status(input logic [3:0] base, input logic [3:0] ch);
        logic [3:0] c;
        begin
            c = ch;
            if (ch == 4'd9) begin
                c = 4'd15;
            end else if (ch == 4'd15) begin
                c = 4'd9;
            end
            chan_status = {base, c};
        end
    endfunction

    // System event number 10..14 to controller number.
    function automatic logic [7:0] sys_map(input logic [7:0] code);
        begin
            case (code)
                8'd10:   sys_map = 8'h78;
                8'd11:   sys_map = 8'h7B;
                8'd12:   sys_map = 8'h7E;
                8'd13:   sys_map = 8'h7F;
                8'd14:   sys_map = 8'h79;
                default: sys_map = 8'h00;
            endcase
        end
    endfunction

    // MUS controller number 1..9 to MIDI controller number.
    function automatic logic [7:0] ctl_map(input logic [3:0] num);
        begin
            case (num)
                4'd2:    ctl_map = 8'h01;
                4'd3:    ctl_map = 8'h07;
                4'd4:    ctl_map = 8'h0A;
                4'd5:    ctl_map = 8'h0B;
                4'd6:    ctl_map = 8'h5B;
                4'd7:    ctl_map = 8'h5D;
                4'd8:    ctl_map = 8'h40;
                4'd9:    ctl_map = 8'h43;
                default: ctl_map = 8'h00;
            endcase
        end
    endfunction

endpackage

### sv/mtm_front.sv
// Front end: parses MUS score bytes and builds the output byte groups.
`timescale 1ns / 1ps

module mtm_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          accept,
    input  logic [7:0]    score_byte,
    output logic          push,
    output mtm_pkg::cmd_t cmd
);

    mtm_pkg::phase_t phase_reg, phase_next;
    logic [7:0] event_reg, event_next;
    logic [7:0] first_reg, first_next;
    logic [6:0] vel_reg [16];

    logic       is_cmd;
    logic [1:0] cmd_len;
    logic [3:0] ch;

    assign ch = event_reg[3:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= mtm_pkg::PH_EVENT;
            event_reg <= '0;
            first_reg <= '0;
            for (int i = 0; i < 16; i++) begin
                vel_reg[i] <= mtm_pkg::VEL_RESET;
            end
        end else if (accept) begin
            phase_reg <= phase_next;
            event_reg <= event_next;
            first_reg <= first_next;
            if (phase_reg == mtm_pkg::PH_VELOCITY) begin
                vel_reg[ch] <= score_byte[6:0];
            end
        end
    end

    always_comb begin
        phase_next = phase_reg;
        event_next = event_reg;
        first_next = first_reg;
        cmd        = '0;
        push       = 1'b0;
        is_cmd     = 1'b0;
        cmd_len    = 2'd0;
        case (phase_reg)
            mtm_pkg::PH_EVENT: begin
                event_next = score_byte;
                case (score_byte[6:4])
                    mtm_pkg::KIND_END: begin
                        cmd.bytes[0] = mtm_pkg::MIDI_META;
                        cmd.bytes[1] = mtm_pkg::MIDI_END_TRK;
                        cmd.bytes[2] = 8'h00;
                        cmd.last_idx = 2'd2;
                        cmd.status   = mtm_pkg::ST_END;
                        push         = 1'b1;
                        phase_next   = mtm_pkg::PH_HALT;
                    end
                    mtm_pkg::KIND_RELEASE, mtm_pkg::KIND_PLAY, mtm_pkg::KIND_PITCH,
                    mtm_pkg::KIND_SYSTEM, mtm_pkg::KIND_CTRL: begin
                        phase_next = mtm_pkg::PH_OPERAND;
                    end
                    default: begin
                        cmd.status = mtm_pkg::ST_BAD_EVENT;
                        push       = 1'b1;
                        phase_next = mtm_pkg::PH_HALT;
                    end
                endcase
            end
            mtm_pkg::PH_OPERAND: begin
                case (event_reg[6:4])
                    mtm_pkg::KIND_RELEASE: begin
                        cmd.bytes[0] = mtm_pkg::chan_status(mtm_pkg::MIDI_NOTE_OFF, ch);
                        cmd.bytes[1] = {1'b0, score_byte[6:0]};
                        cmd.bytes[2] = mtm_pkg::RELEASE_VEL;
                        cmd_len      = 2'd2;
                        is_cmd       = 1'b1;
                    end
                    mtm_pkg::KIND_PLAY: begin
                        if (score_byte[7]) begin
                            first_next = score_byte;
                            phase_next = mtm_pkg::PH_VELOCITY;
                        end else begin
                            cmd.bytes[0] = mtm_pkg::chan_status(mtm_pkg::MIDI_NOTE_ON, ch);
                            cmd.bytes[1] = {1'b0, score_byte[6:0]};
                            cmd.bytes[2] = {1'b0, vel_reg[ch]};
                            cmd_len      = 2'd2;
                            is_cmd       = 1'b1;
                        end
                    end
                    mtm_pkg::KIND_PITCH: begin
                        cmd.bytes[0] = mtm_pkg::chan_status(mtm_pkg::MIDI_PITCH, ch);
                        cmd.bytes[1] = 8'h00;
                        cmd.bytes[2] = {1'b0, score_byte[7:1]};
                        cmd_len      = 2'd2;
                        is_cmd       = 1'b1;
                    end
                    mtm_pkg::KIND_SYSTEM: begin
                        if (score_byte inside {[8'd10:8'd14]}) begin
                            cmd.bytes[0] = mtm_pkg::chan_status(mtm_pkg::MIDI_CTRL, ch);
                            cmd.bytes[1] = mtm_pkg::sys_map(score_byte);
                            cmd.bytes[2] = 8'h00;
                            cmd_len      = 2'd2;
                            is_cmd       = 1'b1;
                        end else begin
                            cmd.status = mtm_pkg::ST_BAD_SYSTEM;
                            push       = 1'b1;
                            phase_next = mtm_pkg::PH_HALT;
                        end
                    end
                    default: begin
                        if (score_byte > 8'd9) begin
                            cmd.status = mtm_pkg::ST_BAD_CTRL;
                            push       = 1'b1;
                            phase_next = mtm_pkg::PH_HALT;
                        end else begin
                            first_next = score_byte;
                            phase_next = mtm_pkg::PH_CTRL_VALUE;
                        end
                    end
                endcase
            end
            mtm_pkg::PH_VELOCITY: begin
                cmd.bytes[0] = mtm_pkg::chan_status(mtm_pkg::MIDI_NOTE_ON, ch);
                cmd.bytes[1] = {1'b0, first_reg[6:0]};
                cmd.bytes[2] = {1'b0, score_byte[6:0]};
                cmd_len      = 2'd2;
                is_cmd       = 1'b1;
            end
            mtm_pkg::PH_CTRL_VALUE: begin
                if (first_reg == 8'd0) begin
                    cmd.bytes[0] = mtm_pkg::chan_status(mtm_pkg::MIDI_PROGRAM, ch);
                    cmd.bytes[1] = {1'b0, score_byte[6:0]};
                    cmd_len      = 2'd1;
                end else begin
                    cmd.bytes[0] = mtm_pkg::chan_status(mtm_pkg::MIDI_CTRL, ch);
                    cmd.bytes[1] = mtm_pkg::ctl_map(first_reg[3:0]);
                    cmd.bytes[2] = {1'b0, score_byte[6:0]};
                    cmd_len      = 2'd2;
                end
                is_cmd = 1'b1;
            end
            mtm_pkg::PH_DELAY: begin
                cmd.bytes[0] = score_byte;
                push         = 1'b1;
                if (!score_byte[7]) begin
                    phase_next = mtm_pkg::PH_EVENT;
                end
            end
            default: begin
                phase_next = mtm_pkg::PH_HALT;
            end
        endcase

        // A finished command is followed by a zero delta unless delay bytes follow.
        if (is_cmd) begin
            push = 1'b1;
            if (event_reg[7]) begin
                cmd.last_idx = cmd_len;
                phase_next   = mtm_pkg::PH_DELAY;
            end else begin
                cmd.bytes[cmd_len + 2'd1] = 8'h00;
                cmd.last_idx              = cmd_len + 2'd1;
                phase_next                = mtm_pkg::PH_EVENT;
            end
        end
    end

endmodule

### sv/mtm_queue.sv
// Two-entry queue of byte groups between the parser and the serialiser.
`timescale 1ns / 1ps

module mtm_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  mtm_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          avail,
    output mtm_pkg::cmd_t head
);

    mtm_pkg::cmd_t entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign avail   = (count_reg != 2'd0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && avail;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### sv/mtm_back.sv
// Back end: sends the bytes of each group one per cycle on the result channel while m_ready is high.
`timescale 1ns / 1ps

module mtm_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          avail,
    input  mtm_pkg::cmd_t head,
    output logic          pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_midi_byte,
    output logic          m_last,
    output logic [2:0]    m_status
);

    mtm_pkg::cmd_t cur_reg;
    logic          busy_reg;
    logic [1:0]    idx_reg;
    logic          need_load;

    assign m_valid     = busy_reg;
    assign m_midi_byte = cur_reg.bytes[idx_reg];
    assign m_last      = (idx_reg == cur_reg.last_idx);
    assign m_status    = cur_reg.status;

    assign need_load = !busy_reg || (m_ready && m_last);
    assign pop       = need_load && avail;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end else if (need_load) begin
            busy_reg <= avail;
            idx_reg  <= 2'd0;
        end else if (m_ready) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= head;
        end
    end

endmodule

### sv/mus_to_midi_event_transcoder_top.sv
// Top level of the MUS to MIDI event transcoder.
`timescale 1ns / 1ps

// This block takes a MUS score one byte per item and returns the MIDI track event
// bytes, each command followed by its delta time; the file header and track length
// are not produced. Input items are taken one per cycle while the two-entry queue
// between parser and serialiser has room; a byte that completes nothing queues no
// output, and a delay byte queues a single output byte. The serialiser sends one
// output item per cycle while m_ready is high, so an input byte that completes a
// command causes up to four output bytes (note, pitch wheel, system and controller
// events with a zero delta), three for the end of score. The output serialiser
// therefore sets the sustained rate. Errors give a single item with midi_byte zero
// and a non-zero status; after an error or the end of score, further input items
// are accepted and dropped until reset.

module mus_to_midi_event_transcoder_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_score_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_midi_byte,
    output logic       m_last,
    output logic [2:0] m_status
);

    logic          q_full;
    logic          q_avail;
    logic          q_pop;
    logic          f_push;
    logic          accept;
    mtm_pkg::cmd_t f_cmd;
    mtm_pkg::cmd_t q_head;

    // The parser only stalls when the queue is full.
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    mtm_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .score_byte (s_score_byte),
        .push       (f_push),
        .cmd        (f_cmd)
    );

    // Groups are only queued for accepted items that produce output.
    mtm_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (f_push && accept),
        .push_cmd (f_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .avail    (q_avail),
        .head     (q_head)
    );

    mtm_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .avail       (q_avail),
        .head        (q_head),
        .pop         (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_midi_byte (m_midi_byte),
        .m_last      (m_last),
        .m_status    (m_status)
    );

endmodule
